// File: hdl/descriptor_slot_table_assert.svh
`ifndef DESCRIPTOR_SLOT_TABLE_ASSERT_SVH
`define DESCRIPTOR_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define DST_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define DST_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dst_pkg.sv
package dst_pkg;

  localparam int DEF_SLOT_COUNT = 256;
  localparam int GROUP_LOG      = 4;
  localparam int GROUP_SIZE     = 1 << GROUP_LOG;

  localparam int FUNC_W   = 2;
  localparam int SLOTN_W  = 16;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int SLOTO_W  = 8;
  localparam int OCC_W    = 9;
  localparam int CFG_W    = 8;

  localparam int IN_BITS  = FUNC_W + SLOTN_W + HANDLE_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + SLOTO_W + HANDLE_W + OCC_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] FIRST_SLOT_RESET = 8'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSTALL    = 2'd0,
    FN_INSTALL_AT = 2'd1,
    FN_LOOKUP     = 2'd2,
    FN_REMOVE     = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADSLOT = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

// File: hdl/dst_handle_ram.sv
module dst_handle_ram #(
  parameter int DEPTH  = dst_pkg::DEF_SLOT_COUNT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [dst_pkg::HANDLE_W-1:0]  wdata,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [dst_pkg::HANDLE_W-1:0]  rdata
);
  import dst_pkg::*;

  logic [HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/dst_free_search.sv
`include "descriptor_slot_table_assert.svh"

module dst_free_search #(
  parameter int SLOT_COUNT = dst_pkg::DEF_SLOT_COUNT,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [SLOT_COUNT-1:0]     busy,
  input  logic [dst_pkg::CFG_W-1:0] first_slot,
  output logic                      found,
  output logic [IDX_W-1:0]          found_slot
);
  import dst_pkg::*;

  localparam int GRP_COUNT = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W     = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;
  localparam int PAD_COUNT = GRP_COUNT * GROUP_SIZE;

  logic [PAD_COUNT-1:0] free_vec;
  logic [GRP_COUNT-1:0] grp_free;
  logic [GROUP_LOG-1:0] grp_off [GRP_COUNT];
  logic [GRP_COUNT-1:0] grp_free_next;
  logic [GROUP_LOG-1:0] grp_off_next [GRP_COUNT];
  logic [GRP_W-1:0]     pick_grp;

  // Eligible: inside the table, at or above the start slot, and empty
  always_comb begin
    for (int i = 0; i < PAD_COUNT; i++) begin
      if (i < SLOT_COUNT) begin
        free_vec[i] = !busy[i] && (i >= int'(first_slot));
      end else begin
        free_vec[i] = 1'b0;
      end
    end
  end

  // First level: lowest free offset inside each group of sixteen
  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_free_next[g] = |free_vec[g*GROUP_SIZE +: GROUP_SIZE];
      grp_off_next[g]  = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (free_vec[g*GROUP_SIZE + b]) begin
          grp_off_next[g] = GROUP_LOG'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free <= grp_free_next;
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_off[g] <= grp_off_next[g];
    end
  end

  // Second level: lowest group with a free slot
  always_comb begin
    pick_grp = '0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        pick_grp = GRP_W'(g);
      end
    end
  end

  assign found      = |grp_free;
  assign found_slot = IDX_W'({pick_grp, grp_off[pick_grp]});

  `DST_ASSERT_IMP(a_found_is_free, clk, rst,
    found && $stable(busy) && $stable(first_slot),
    !busy[found_slot] && (int'(found_slot) >= int'(first_slot)),
    "search returned a busy or reserved slot")

endmodule

// File: hdl/descriptor_slot_table.sv
// A result is registered as the execute state that follows its accepted request ends.
// New requests are taken only in idle; the handle RAM read and the per-group free
// summary are registered on acceptance, slot pick and write-back happen in execute.
// A waiting result holds the block in its execute state until taken.
// Reset: busy bits and the occupied count clear in the reset cycle, no clearing
// pass; the start slot returns to 3; handle RAM contents are not reset.
`include "descriptor_slot_table_assert.svh"

module descriptor_slot_table #(
  parameter int SLOT_COUNT = dst_pkg::DEF_SLOT_COUNT
) (
  input  logic                      clk,
  input  logic                      rst,
  // func[1:0], slot_number[17:2], handle_in[49:18], zero fill above
  input  logic [dst_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // status[2:0], slot_out[10:3], handle_out[42:11], occupied_count[51:43], zero fill
  output logic [dst_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic                      cfg_we,
  input  logic [dst_pkg::CFG_W-1:0] cfg_wdata
);
  import dst_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SLOT_COUNT);

  state_t state, state_next;

  logic [CFG_W-1:0]      first_auto_slot;
  logic [SLOT_COUNT-1:0] busy;
  logic [CNT_W-1:0]      busy_total;

  // captured request
  func_t               req_func;
  logic                req_ok;
  logic [IDX_W-1:0]    req_idx;
  logic [HANDLE_W-1:0] req_handle;

  // result register
  logic                out_valid;
  status_t             out_status;
  logic [SLOTO_W-1:0]  out_slot;
  logic [HANDLE_W-1:0] out_handle;
  logic [OCC_W-1:0]    out_count;

  logic                in_fire;
  logic [FUNC_W-1:0]   in_func;
  logic [SLOTN_W-1:0]  in_slot;
  logic [HANDLE_W-1:0] in_handle;
  logic                in_ok;

  logic                found;
  logic [IDX_W-1:0]    found_slot;
  logic [HANDLE_W-1:0] rd_handle;

  logic                exec_done;
  logic                busy_sel;
  logic                do_fill;
  logic                do_clear;
  logic [IDX_W-1:0]    wr_idx;
  status_t             res_status;
  logic [IDX_W-1:0]    res_slot;
  logic [HANDLE_W-1:0] res_handle;
  logic [CNT_W-1:0]    busy_total_next;

  assign in_func   = s_axis_tdata[FUNC_W-1:0];
  assign in_slot   = s_axis_tdata[FUNC_W +: SLOTN_W];
  assign in_handle = s_axis_tdata[FUNC_W+SLOTN_W +: HANDLE_W];
  assign in_ok     = !in_slot[SLOTN_W-1] && (in_slot < SLOTN_W'(SLOT_COUNT));

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  dst_handle_ram #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (exec_done && (do_fill || do_clear)),
    .waddr (wr_idx),
    .wdata (do_fill ? req_handle : '0),
    .re    (in_fire),
    .raddr (in_slot[IDX_W-1:0]),
    .rdata (rd_handle)
  );

  dst_free_search #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .busy       (busy),
    .first_slot (first_auto_slot),
    .found      (found),
    .found_slot (found_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_auto_slot <= FIRST_SLOT_RESET;
    end else if (cfg_we) begin
      first_auto_slot <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func   <= func_t'(in_func);
      req_ok     <= in_ok;
      req_idx    <= in_slot[IDX_W-1:0];
      req_handle <= in_handle;
    end
  end

  assign exec_done = (state == S_EXEC) && (!out_valid || m_axis_tready);
  assign busy_sel  = req_ok && busy[req_idx];

  always_comb begin
    res_status = ST_OK;
    res_slot   = req_idx;
    res_handle = '0;
    do_fill    = 1'b0;
    do_clear   = 1'b0;
    wr_idx     = req_idx;
    unique case (req_func)
      FN_INSTALL: begin
        wr_idx   = found_slot;
        res_slot = found_slot;
        if (req_handle == '0) begin
          res_status = ST_INVALID;
        end else if (found) begin
          do_fill = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      FN_INSTALL_AT: begin
        if (req_handle == '0 || !req_ok) begin
          res_status = ST_INVALID;
        end else if (busy_sel) begin
          res_status = ST_EXISTS;
        end else begin
          do_fill = 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (!busy_sel) begin
          res_status = ST_BADSLOT;
        end else begin
          res_handle = rd_handle;
        end
      end
      FN_REMOVE: begin
        if (!busy_sel) begin
          res_status = ST_BADSLOT;
        end else begin
          res_handle = rd_handle;
          do_clear   = 1'b1;
        end
      end
      default: begin
        res_status = ST_BADSLOT;
      end
    endcase
    if (res_status != ST_OK) begin
      res_slot = '0;
    end
  end

  always_comb begin
    busy_total_next = busy_total;
    if (do_fill && busy_total < CNT_MAX) begin
      busy_total_next = busy_total + CNT_W'(1);
    end else if (do_clear && busy_total != '0) begin
      busy_total_next = busy_total - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= '0;
      busy_total <= '0;
    end else if (exec_done) begin
      busy_total <= busy_total_next;
      if (do_fill) begin
        busy[wr_idx] <= 1'b1;
      end else if (do_clear) begin
        busy[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // load the result only when the slot frees up
  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_status <= res_status;
      out_slot   <= SLOTO_W'(res_slot);
      out_handle <= res_handle;
      out_count  <= OCC_W'(busy_total_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_count, out_handle, out_slot, out_status});

  `DST_ASSERT_NEXT(a_accept_to_exec, clk, rst, in_fire, state == S_EXEC,
    "accepted request did not enter execute")
  `DST_ASSERT_NEXT(a_fill_counts, clk, rst, exec_done && do_fill,
    busy_total == $past(busy_total) + CNT_W'(1), "fill did not raise the count")
  `DST_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, busy_total <= CNT_MAX,
    "occupied count passed the table size")

endmodule
